### design/hcb_pkg.sv
package hcb_pkg;

  localparam logic [31:0] CRC_POLY   = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT   = 32'hFFFF_FFFF;
  localparam logic [31:0] VIDEO_WORD = 32'h00F0_0100;
  // "CRT1" packed little-endian
  localparam logic [31:0] MAGIC_WORD = 32'h3154_5243;

  localparam logic [7:0] VERSION_BYTE = 8'd1;
  localparam logic [7:0] VIDEO_KIND   = 8'd1;
  localparam logic [7:0] VIDEO_FMT    = 8'd1;

  localparam logic [7:0] AUDIO_KIND_RST = 8'd2;
  localparam logic [7:0] AV_KIND_RST    = 8'd3;

  localparam logic       ACT_DATA  = 1'b0;
  localparam logic       ACT_CLOSE = 1'b1;

  localparam logic [1:0] KIND_VIDEO = 2'd0;
  localparam logic [1:0] KIND_AUDIO = 2'd1;
  localparam logic [1:0] KIND_AV    = 2'd2;

  localparam logic       REG_AUDIO_KIND = 1'b0;
  localparam logic       REG_AV_KIND    = 1'b1;

  localparam logic [4:0] HCRC_END_INDEX = 5'd24;
  localparam logic [4:0] LAST_INDEX     = 5'd31;

  typedef struct packed {
    logic [7:0]  kind_byte;
    logic [7:0]  fmt_byte;
    logic [31:0] seq;
    logic [31:0] length;
    logic [31:0] word;
    logic [31:0] pcrc;
  } hdr_desc_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic [31:0] crc_byte(logic [31:0] c, logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'b0, b};
    for (int k = 0; k < 8; k++) begin
      r = (r >> 1) ^ (CRC_POLY & {32{r[0]}});
    end
    return r;
  endfunction

endpackage

### design/hcb_front.sv
module hcb_front
  import hcb_pkg::*;
#(
  parameter int LENGTH_BITS = 20
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        action,
  input  logic [7:0]  data_byte,
  input  logic [1:0]  packet_kind,
  input  logic [7:0]  audio_format,
  input  logic [31:0] sequence_number,
  input  logic [31:0] sample_rate,
  input  logic [7:0]  audio_kind_code,
  input  logic [7:0]  av_kind_code,
  input  q_status_t   q_status,
  output logic        push,
  output hdr_desc_t   push_desc
);

  localparam logic [LENGTH_BITS-1:0] COUNT_MAX = {LENGTH_BITS{1'b1}};

  logic [31:0]            running_crc;
  logic [LENGTH_BITS-1:0] payload_count;
  logic                   accept;

  assign in_ready = !q_status.full;
  assign accept   = in_valid && in_ready;
  assign push     = accept && (action == ACT_CLOSE);

  always_comb begin
    push_desc.seq    = sequence_number;
    push_desc.length = 32'(payload_count);
    push_desc.pcrc   = ~running_crc;
    case (packet_kind)
      KIND_AUDIO: begin
        push_desc.kind_byte = audio_kind_code;
        push_desc.fmt_byte  = audio_format;
        push_desc.word      = sample_rate;
      end
      KIND_AV: begin
        push_desc.kind_byte = av_kind_code;
        push_desc.fmt_byte  = audio_format;
        push_desc.word      = VIDEO_WORD;
      end
      default: begin
        push_desc.kind_byte = VIDEO_KIND;
        push_desc.fmt_byte  = VIDEO_FMT;
        push_desc.word      = VIDEO_WORD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_crc   <= CRC_INIT;
      payload_count <= '0;
    end else if (accept) begin
      if (action == ACT_CLOSE) begin
        running_crc   <= CRC_INIT;
        payload_count <= '0;
      end else begin
        running_crc <= crc_byte(running_crc, data_byte);
        if (payload_count != COUNT_MAX) begin
          payload_count <= payload_count + 1'b1;
        end
      end
    end
  end

endmodule

### design/hcb_queue.sv
module hcb_queue
  import hcb_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  hdr_desc_t push_desc,
  input  logic      pop,
  output hdr_desc_t head,
  output q_status_t q_status
);

  // two-entry shift queue, slot0 is the head
  hdr_desc_t  slot0;
  hdr_desc_t  slot1;
  logic [1:0] count;

  assign head           = slot0;
  assign q_status.full  = (count == 2'd2);
  assign q_status.empty = (count == 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case ({push, pop})
      2'b10: begin
        if (count == 2'd0) begin
          slot0 <= push_desc;
        end else begin
          slot1 <= push_desc;
        end
      end
      2'b01: begin
        slot0 <= slot1;
      end
      2'b11: begin
        if (count == 2'd1) begin
          slot0 <= push_desc;
        end else begin
          slot0 <= slot1;
          slot1 <= push_desc;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

### design/hcb_back.sv
module hcb_back
  import hcb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  hdr_desc_t  head,
  input  q_status_t  q_status,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] header_byte,
  output logic [4:0] byte_index,
  output logic       last
);

  localparam logic [2:0] GRP_MAGIC  = 3'd0;
  localparam logic [2:0] GRP_INFO   = 3'd1;
  localparam logic [2:0] GRP_SEQ    = 3'd2;
  localparam logic [2:0] GRP_LENGTH = 3'd3;
  localparam logic [2:0] GRP_WORD   = 3'd4;
  localparam logic [2:0] GRP_PCRC   = 3'd5;
  localparam logic [2:0] GRP_HCRC   = 3'd6;

  logic [4:0]  idx;
  logic [31:0] hcrc;
  logic [31:0] cur_word;
  logic [7:0]  cur_byte;
  logic        advance;

  assign advance = !q_status.empty && (!out_valid || out_ready);
  assign pop     = advance && (idx == LAST_INDEX);

  always_comb begin
    case (idx[4:2])
      GRP_MAGIC:  cur_word = MAGIC_WORD;
      GRP_INFO:   cur_word = {VERSION_BYTE, head.fmt_byte, head.kind_byte, VERSION_BYTE};
      GRP_SEQ:    cur_word = head.seq;
      GRP_LENGTH: cur_word = head.length;
      GRP_WORD:   cur_word = head.word;
      GRP_PCRC:   cur_word = head.pcrc;
      GRP_HCRC:   cur_word = ~hcrc;
      default:    cur_word = 32'd0;
    endcase
    case (idx[1:0])
      2'd0:    cur_byte = cur_word[7:0];
      2'd1:    cur_byte = cur_word[15:8];
      2'd2:    cur_byte = cur_word[23:16];
      default: cur_byte = cur_word[31:24];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      hcrc      <= CRC_INIT;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
        idx       <= idx + 5'd1;
        if (idx == LAST_INDEX) begin
          hcrc <= CRC_INIT;
        end else if (idx < HCRC_END_INDEX) begin
          hcrc <= crc_byte(hcrc, cur_byte);
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      header_byte <= cur_byte;
      byte_index  <= idx;
      last        <= (idx == LAST_INDEX);
    end
  end

endmodule

### design/packet_header_crc_builder_unit.sv
// packet header builder with running crc-32
// input channel: one beat per item; action selects a payload byte or a close.
// payload beats update the reflected crc-32 and a saturating byte count and
// produce no output. a close beat snapshots the header fields into a
// two-entry queue and restarts the crc and count for the next packet.
// output channel: each close yields 32 header beats (header_byte, byte_index,
// last on index 31). the header crc over bytes 0..23 is built one byte per
// beat as the bytes go out, so bytes 24..27 follow at once.
// throughput: one input beat per cycle while the queue has room; one header
// beat per cycle while the receiver is ready. a close beat's header goes into
// the queue first; its first beat is then registered into the output register.
// when the receiver stalls, the output register holds its beat; input is
// still taken until two closes are waiting, then in_ready drops.
// reset (rst, synchronous): crc to all ones, count to zero, queue empty,
// kind registers to 2 (audio) and 3 (video plus audio).
// apb: register 0 audio kind at 0x0, register 1 av kind at 0x4.
module packet_header_crc_builder_unit
  import hcb_pkg::*;
#(
  parameter int LENGTH_BITS = 20
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        action,
  input  logic [7:0]  data_byte,
  input  logic [1:0]  packet_kind,
  input  logic [7:0]  audio_format,
  input  logic [31:0] sequence_number,
  input  logic [31:0] sample_rate,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  header_byte,
  output logic [4:0]  byte_index,
  output logic        last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [7:0] audio_kind_code;
  logic [7:0] av_kind_code;
  logic       push;
  logic       pop;
  hdr_desc_t  push_desc;
  hdr_desc_t  head;
  q_status_t  q_status;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      audio_kind_code <= AUDIO_KIND_RST;
      av_kind_code    <= AV_KIND_RST;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[2])
        REG_AUDIO_KIND: audio_kind_code <= pwdata[7:0];
        REG_AV_KIND:    av_kind_code    <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_AUDIO_KIND: prdata = {24'd0, audio_kind_code};
      REG_AV_KIND:    prdata = {24'd0, av_kind_code};
      default:        prdata = 32'd0;
    endcase
  end

  hcb_front #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .action         (action),
    .data_byte      (data_byte),
    .packet_kind    (packet_kind),
    .audio_format   (audio_format),
    .sequence_number(sequence_number),
    .sample_rate    (sample_rate),
    .audio_kind_code(audio_kind_code),
    .av_kind_code   (av_kind_code),
    .q_status       (q_status),
    .push           (push),
    .push_desc      (push_desc)
  );

  hcb_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_desc(push_desc),
    .pop      (pop),
    .head     (head),
    .q_status (q_status)
  );

  hcb_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .q_status   (q_status),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .header_byte(header_byte),
    .byte_index (byte_index),
    .last       (last)
  );

endmodule

### design/hcb_checker.sv
module hcb_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] header_byte,
  input logic [4:0] byte_index,
  input logic       last
);

  // last marks exactly the final header byte
  a_last_index: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last == (byte_index == 5'd31)))
    else $error("last does not match byte_index");

  // header beats of one packet go out back to back
  a_next_beat: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !last) |=>
      (out_valid && byte_index == $past(byte_index) + 5'd1))
    else $error("header beat missing or out of order");

  // every header opens with the magic byte
  a_magic: assert property (@(posedge clk) disable iff (rst)
    (out_valid && byte_index == 5'd0) |-> (header_byte == 8'h43))
    else $error("bad magic byte");

  // a stalled beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(byte_index) && $stable(header_byte)))
    else $error("stalled output beat changed");

endmodule

bind packet_header_crc_builder_unit hcb_checker u_hcb_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .header_byte(header_byte),
  .byte_index (byte_index),
  .last       (last)
);
